// ===== design/vt4_pkg.sv =====
// vt4_pkg: shared types, widths and constants for the 4x4 vertex transform core.
// No dependencies; every other design file refers to it by scoped names.
package vt4_pkg;

  localparam int FracBits = 16;            // Q16.16 by default, valid range 8..24
  localparam int DataW    = 32;
  localparam int NumLanes = 4;             // one lane per output row
  localparam int NumCols  = 4;
  localparam int NumElem  = NumLanes * NumCols;
  localparam int IdxW     = $clog2(NumElem);
  localparam int ProdW    = 2 * DataW;     // exact product
  localparam int PairW    = ProdW + 1;     // sum of two products
  localparam int SumW     = ProdW + 2;     // sum of four products
  localparam int ShW      = SumW - FracBits;

  localparam logic signed [DataW-1:0] OneFix = DataW'(1) << FracBits;

  typedef enum logic [1:0] {
    OpLoadElem  = 2'd0,
    OpLoadIdent = 2'd1,
    OpXformVec  = 2'd2,
    OpXformPt   = 2'd3
  } opcode_e;

  typedef logic signed [DataW-1:0] fix_t;
  typedef logic signed [PairW-1:0] pair_t;

  // pipeline advance strobes handed to each lane
  typedef struct packed {
    logic s1_en;
    logic s2_en;
  } lane_ctrl_t;

  // column-major: element k is row k[1:0], column k[3:2]
  function automatic fix_t identity_elem(logic [IdxW-1:0] k);
    return (k[1:0] == k[3:2]) ? OneFix : '0;
  endfunction

endpackage

// ===== design/vt4_in_if.sv =====
// vt4_in_if / vt4_out_if: valid/ready channels of the vertex transform core.
// Depends on vt4_pkg for payload types.
interface vt4_in_if;
  logic                          valid;
  logic                          ready;
  vt4_pkg::opcode_e              opcode;
  logic [vt4_pkg::IdxW-1:0]      element_index;
  vt4_pkg::fix_t                 element_value;
  vt4_pkg::fix_t                 comp_x;
  vt4_pkg::fix_t                 comp_y;
  vt4_pkg::fix_t                 comp_z;
  vt4_pkg::fix_t                 comp_w;

  modport source (output valid, opcode, element_index, element_value,
                  comp_x, comp_y, comp_z, comp_w, input ready);
  modport sink   (input valid, opcode, element_index, element_value,
                  comp_x, comp_y, comp_z, comp_w, output ready);
endinterface

interface vt4_out_if;
  logic          valid;
  logic          ready;
  vt4_pkg::fix_t out_x;
  vt4_pkg::fix_t out_y;
  vt4_pkg::fix_t out_z;
  vt4_pkg::fix_t out_w;

  modport source (output valid, out_x, out_y, out_z, out_w, input ready);
  modport sink   (input valid, out_x, out_y, out_z, out_w, output ready);
endinterface

// ===== design/vt4_lane.sv =====
// vt4_lane: one output row. Four registered 32x32 products, then two pair sums.
// Depends on vt4_pkg.
module vt4_lane (
  input  logic                clk_i,
  input  vt4_pkg::lane_ctrl_t ctrl_i,
  input  vt4_pkg::fix_t       row_i  [vt4_pkg::NumCols],
  input  vt4_pkg::fix_t       vec_i  [vt4_pkg::NumCols],
  output vt4_pkg::pair_t      pair_o [2]
);

  logic signed [vt4_pkg::ProdW-1:0] prod_q [vt4_pkg::NumCols];
  vt4_pkg::pair_t                   pair_q [2];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s1_en) begin
      for (int c = 0; c < vt4_pkg::NumCols; c++) begin
        prod_q[c] <= vt4_pkg::ProdW'(row_i[c]) * vt4_pkg::ProdW'(vec_i[c]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s2_en) begin
      pair_q[0] <= vt4_pkg::PairW'(prod_q[0]) + vt4_pkg::PairW'(prod_q[1]);
      pair_q[1] <= vt4_pkg::PairW'(prod_q[2]) + vt4_pkg::PairW'(prod_q[3]);
    end
  end

  assign pair_o = pair_q;

endmodule

// ===== design/vt4_merge.sv =====
// vt4_merge: final row sums, floor shift, saturation and point-mode w override.
// Holds the output register. Depends on vt4_pkg.
module vt4_merge (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic           point_i,
  input  vt4_pkg::pair_t pair_i [vt4_pkg::NumLanes][2],
  output vt4_pkg::fix_t  res_o  [vt4_pkg::NumLanes]
);

  vt4_pkg::fix_t res_d [vt4_pkg::NumLanes];
  vt4_pkg::fix_t res_q [vt4_pkg::NumLanes];

  function automatic vt4_pkg::fix_t sat_row(vt4_pkg::pair_t a, vt4_pkg::pair_t b);
    logic signed [vt4_pkg::SumW-1:0] sum;
    logic signed [vt4_pkg::ShW-1:0]  sh;
    logic                            ovf;
    sum = vt4_pkg::SumW'(a) + vt4_pkg::SumW'(b);
    sh  = vt4_pkg::ShW'(sum >>> vt4_pkg::FracBits);   // arithmetic: floor
    // in range only if bits above 31 all copy the sign
    ovf = (sh[vt4_pkg::ShW-1:vt4_pkg::DataW-1] != '0) &&
          (sh[vt4_pkg::ShW-1:vt4_pkg::DataW-1] != '1);
    if (!ovf)                  return sh[vt4_pkg::DataW-1:0];
    if (sh[vt4_pkg::ShW-1])    return {1'b1, {(vt4_pkg::DataW-1){1'b0}}};
    return {1'b0, {(vt4_pkg::DataW-1){1'b1}}};
  endfunction

  always_comb begin
    for (int r = 0; r < vt4_pkg::NumLanes; r++) begin
      res_d[r] = sat_row(pair_i[r][0], pair_i[r][1]);
    end
    if (point_i) res_d[vt4_pkg::NumLanes-1] = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

// ===== design/vertex_transform_4x4_core.sv =====
// vertex_transform_4x4_core: top level. Matrix store, pipeline control,
// four row lanes and the merge stage. Depends on vt4_pkg, vt4_in_if/vt4_out_if,
// vt4_lane and vt4_merge.
//
//   channel   dir   beat contents
//   in_i      in    opcode, element_index, element_value, comp_x/y/z/w
//   out_o     out   out_x, out_y, out_z, out_w
//
// Throughput is one beat per cycle for every opcode while in_i.ready is high. A
// transform beat passes the three register stages (products, pair sums, final
// sum with saturation), the first loading at its accepting edge, and is then
// offered on out_o.
// Loads (single element or identity) update the matrix at the accepting edge
// and the very next beat sees the new matrix; they produce no output beat.
// Reset (rst_ni low, async) empties the pipe and restores the identity matrix.
// Stalls on out_o hold each stage; bubbles between stages still collapse, so
// in_i.ready drops only when all three stages are full and out_o is stalled.
module vertex_transform_4x4_core (
  input  logic clk_i,
  input  logic rst_ni,
  vt4_in_if.sink    in_i,
  vt4_out_if.source out_o
);

  // ---------------------------------------------------------------------------
  // Matrix store: 16 entries, each lane taps its own fixed row
  // ---------------------------------------------------------------------------
  vt4_pkg::fix_t mat_q [vt4_pkg::NumElem];
  vt4_pkg::fix_t mat_d [vt4_pkg::NumElem];

  logic accept;
  logic acc_xform;

  assign accept    = in_i.valid && in_i.ready;
  assign acc_xform = accept && ((in_i.opcode == vt4_pkg::OpXformVec) ||
                                (in_i.opcode == vt4_pkg::OpXformPt));

  always_comb begin
    mat_d = mat_q;
    if (accept) begin
      unique case (in_i.opcode)
        vt4_pkg::OpLoadElem: mat_d[in_i.element_index] = in_i.element_value;
        vt4_pkg::OpLoadIdent: begin
          for (int k = 0; k < vt4_pkg::NumElem; k++) begin
            mat_d[k] = vt4_pkg::identity_elem(vt4_pkg::IdxW'(k));
          end
        end
        default: ;  // transforms leave the matrix alone
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < vt4_pkg::NumElem; k++) begin
        mat_q[k] <= vt4_pkg::identity_elem(vt4_pkg::IdxW'(k));
      end
    end else begin
      mat_q <= mat_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: per-stage valid, advance when the next stage frees up
  // ---------------------------------------------------------------------------
  logic v1_q, v2_q, ov_q;
  logic v1_d, v2_d, ov_d;
  logic pt1_q, pt2_q;
  logic en1, en2, en3;
  vt4_pkg::lane_ctrl_t lane_ctrl;

  assign en3 = !ov_q || out_o.ready;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign in_i.ready      = en1;
  assign lane_ctrl.s1_en = en1;
  assign lane_ctrl.s2_en = en2;

  always_comb begin
    v1_d = v1_q;
    v2_d = v2_q;
    ov_d = ov_q;
    if (en1) v1_d = acc_xform;
    if (en2) v2_d = v1_q;
    if (en3) ov_d = v2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      ov_q <= ov_d;
    end
  end

  // point flag rides along with the data
  always_ff @(posedge clk_i) begin
    if (en1) pt1_q <= (in_i.opcode == vt4_pkg::OpXformPt);
    if (en2) pt2_q <= pt1_q;
  end

  // ---------------------------------------------------------------------------
  // Lanes: row r uses entries c*4+r; point mode feeds 1.0 as w
  // ---------------------------------------------------------------------------
  vt4_pkg::fix_t  vec   [vt4_pkg::NumCols];
  vt4_pkg::pair_t pairs [vt4_pkg::NumLanes][2];

  assign vec[0] = in_i.comp_x;
  assign vec[1] = in_i.comp_y;
  assign vec[2] = in_i.comp_z;
  assign vec[3] = (in_i.opcode == vt4_pkg::OpXformPt) ? vt4_pkg::OneFix : in_i.comp_w;

  for (genvar r = 0; r < vt4_pkg::NumLanes; r++) begin : g_lane
    vt4_pkg::fix_t row [vt4_pkg::NumCols];
    for (genvar c = 0; c < vt4_pkg::NumCols; c++) begin : g_tap
      assign row[c] = mat_q[c * vt4_pkg::NumLanes + r];
    end
    vt4_lane u_lane (
      .clk_i  (clk_i),
      .ctrl_i (lane_ctrl),
      .row_i  (row),
      .vec_i  (vec),
      .pair_o (pairs[r])
    );
  end

  // ---------------------------------------------------------------------------
  // Merge stage and output register
  // ---------------------------------------------------------------------------
  vt4_pkg::fix_t res [vt4_pkg::NumLanes];

  vt4_merge u_merge (
    .clk_i   (clk_i),
    .en_i    (en3),
    .point_i (pt2_q),
    .pair_i  (pairs),
    .res_o   (res)
  );

  assign out_o.valid = ov_q;
  assign out_o.out_x = res[0];
  assign out_o.out_y = res[1];
  assign out_o.out_z = res[2];
  assign out_o.out_w = res[3];

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // identity load sets entries 0 and 15 to 1.0 and entry 1 to zero
  a_ident: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_i.opcode == vt4_pkg::OpLoadIdent) |=>
      (mat_q[0] == vt4_pkg::OneFix) && (mat_q[15] == vt4_pkg::OneFix) &&
      (mat_q[1] == '0))
    else $error("identity load did not restore matrix");

  // element load lands where addressed
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_i.opcode == vt4_pkg::OpLoadElem) |=>
      mat_q[$past(in_i.element_index)] == $past(in_i.element_value))
    else $error("element load lost");

  // a held middle-stage beat is never dropped
  a_hold2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !en2 |=> v2_q)
    else $error("stage 2 beat dropped while stalled");

  // input backpressure only when the whole pipe is full and out_o is stalled
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (v1_q && v2_q && ov_q && !out_o.ready))
    else $error("input stalled with room in pipe");

endmodule
